/* hdl/first_fit_heap_allocator_unit_defines.svh */
// ----------------------------------------------------------------------------
// First-fit heap allocator assertion macros
// Concurrent check wrappers shared by the allocator RTL, clocked on the
// rising edge and disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define FFHA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define FFHA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ffha_pkg.sv */
// ----------------------------------------------------------------------------
// ffha_pkg
// Sizes, header layout, status codes and control structs of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

    localparam int unsigned HEAP_BYTES = 4096;
    localparam int unsigned HDR_BYTES  = 16;
    localparam int unsigned AW         = $clog2(HEAP_BYTES);
    localparam int unsigned TOP_W      = AW + 1;
    localparam int unsigned POS_W      = AW + 2;
    localparam int unsigned REQ_W      = 12;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned STAT_W     = 2;
    localparam int unsigned ALU_W      = ADDR_W + 1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_RANGE
    } status_t;

    typedef logic [AW-1:0]     off_t;
    typedef logic [AW-1:0]     size_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [TOP_W-1:0]  top_t;
    typedef logic [REQ_W-1:0]  req_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [ALU_W-1:0]  alu_word_t;

    // One block header: used flag and payload size.
    typedef struct packed {
        logic  used;
        size_t size;
    } hdr_t;

    localparam int unsigned HDR_W = $bits(hdr_t);

    // Header store access issued by the sequencer.
    typedef struct packed {
        logic we;
        off_t waddr;
        hdr_t wdata;
        off_t raddr;
    } mem_req_t;

    // Shared adder/comparator control: sum = a +/- (b + 16*hdr), compared to c.
    typedef struct packed {
        logic      sub;
        logic      hdr;
        alu_word_t a;
        alu_word_t b;
        alu_word_t c;
    } alu_ctrl_t;

    typedef struct packed {
        alu_word_t sum;
        logic      lt;
        logic      eq;
    } alu_res_t;

    typedef struct packed {
        logic busy;
        top_t heap_top;
    } seq_stat_t;

endpackage

`default_nettype wire

/* hdl/ffha_if.sv */
// ----------------------------------------------------------------------------
// ffha channel interfaces
// Valid/ready channels for requests, results and the base address write.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffha_req_if;
    logic                 valid;
    logic                 ready;
    logic                 func;
    ffha_pkg::req_t       request_bytes;
    ffha_pkg::addr_t      block_address;

    modport source (output valid, func, request_bytes, block_address, input ready);
    modport sink   (input valid, func, request_bytes, block_address, output ready);
endinterface

interface ffha_rsp_if;
    logic                 valid;
    logic                 ready;
    ffha_pkg::addr_t      address;
    ffha_pkg::status_t    status;

    modport source (output valid, address, status, input ready);
    modport sink   (input valid, address, status, output ready);
endinterface

interface ffha_cfg_if;
    logic                 valid;
    logic                 ready;
    ffha_pkg::addr_t      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/first_fit_heap_allocator_unit.sv */
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_unit
// First-fit heap manager over an implicit chain of 16-byte block headers.
// ----------------------------------------------------------------------------
// The unit manages a HEAP_BYTES heap above a programmable base address. Each
// request beat (allocate or free) runs to completion before the next one is
// taken: req.ready is high only while the sequencer is idle. An allocate
// visits the block headers in order until a free block fits, or walks the
// whole chain and grows the heap; a free clears the used flag of its block,
// then walks the whole chain and merges each run of free blocks. A free
// outside the heap is refused before any header is read. The walk is paced
// by the single read port of the header RAM, whose read data is registered,
// and by the one shared adder/comparator that serves every address and size
// sum. The result beat waits in an output register, so a new request may be
// taken while it is still pending; a finished request holds until that
// register is free. The header RAM is not cleared after reset: a walk reads
// only headers below the heap top, which earlier requests wrote. Write the
// base address only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_heap_allocator_unit_defines.svh"

module first_fit_heap_allocator_unit (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ffha_cfg_if.sink    cfg,
    ffha_req_if.sink    req,
    ffha_rsp_if.source  rsp
);

    // base address register, always ready for a write beat
    ffha_pkg::addr_t              heap_base_reg;
    ffha_pkg::addr_t              heap_base_next;

    ffha_pkg::mem_req_t           mem;
    ffha_pkg::seq_stat_t          stat;
    ffha_pkg::hdr_t               rd_hdr;
    logic [ffha_pkg::HDR_W-1:0]   ram_rdata;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        heap_base_next = heap_base_reg;
        if (cfg.valid)
        begin
            heap_base_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg <= '0;
        end
        else
        begin
            heap_base_reg <= heap_base_next;
        end
    end

    // header store: one entry per byte offset, used flag plus payload size
    ffha_ram #(
        .WIDTH (ffha_pkg::HDR_W),
        .DEPTH (ffha_pkg::HEAP_BYTES)
    ) u_hdr_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (ram_rdata)
    );

    assign rd_hdr = ffha_pkg::hdr_t'(ram_rdata);

    // walk sequencer with the shared adder; owns heap top and the result register
    ffha_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .heap_base (heap_base_reg),
        .rd_hdr    (rd_hdr),
        .mem       (mem),
        .stat      (stat)
    );

    // error results never carry an address
    `FFHA_ASSERT_IMP(a_err_addr_zero, clk, rst_n,
        rsp.valid && (rsp.status != ffha_pkg::ST_OK), rsp.address == '0,
        "error result with nonzero address")

    // the heap never grows past its size
    `FFHA_ASSERT_IMP(a_top_bound, clk, rst_n,
        1'b1, stat.heap_top <= ffha_pkg::TOP_W'(ffha_pkg::HEAP_BYTES),
        "heap top beyond heap size")

    // an accepted request puts the sequencer to work
    `FFHA_ASSERT_NXT(a_accept_busy, clk, rst_n,
        req.valid && req.ready, stat.busy,
        "accepted request did not start the walk")

    // no header writes while idle
    `FFHA_ASSERT_IMP(a_idle_no_write, clk, rst_n,
        !stat.busy, !mem.we,
        "header write while idle")

endmodule

`default_nettype wire

/* hdl/ffha_ram.sv */
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ram #(
    parameter int unsigned WIDTH = 13,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/ffha_alu.sv */
// ----------------------------------------------------------------------------
// ffha_alu
// Shared adder/subtractor with header-size offset and magnitude compare.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_alu (
    input  wire ffha_pkg::alu_ctrl_t ctrl,
    output ffha_pkg::alu_res_t       res
);

    ffha_pkg::alu_word_t opnd;
    ffha_pkg::alu_word_t sum;

    always_comb
    begin
        opnd = ctrl.b + (ctrl.hdr ? ffha_pkg::alu_word_t'(ffha_pkg::HDR_BYTES) : '0);
        sum  = ctrl.sub ? (ctrl.a - opnd) : (ctrl.a + opnd);
        res.sum = sum;
        res.lt  = (sum < ctrl.c);
        res.eq  = (sum == ctrl.c);
    end

endmodule

`default_nettype wire

/* hdl/ffha_seq.sv */
// ----------------------------------------------------------------------------
// ffha_seq
// Sequencer: walks the header chain for allocate and free/merge requests.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_seq (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ffha_req_if.sink                   req,
    ffha_rsp_if.source                 rsp,
    input  wire ffha_pkg::addr_t       heap_base,
    input  wire ffha_pkg::hdr_t        rd_hdr,
    output ffha_pkg::mem_req_t         mem,
    output ffha_pkg::seq_stat_t        stat
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_A_TEST,
        S_A_EVAL,
        S_A_REM,
        S_A_SPLIT,
        S_A_ADDR,
        S_A_END,
        S_F_LO,
        S_F_HI,
        S_F_RD,
        S_F_CLR,
        S_M_TEST,
        S_M_EVAL,
        S_M_NTEST,
        S_M_NEVAL,
        S_M_NADV,
        S_M_WRITE,
        S_DONE
    } state_t;

    state_t              state_reg,    state_next;
    ffha_pkg::req_t      rq_reg,       rq_next;
    ffha_pkg::addr_t     baddr_reg,    baddr_next;
    ffha_pkg::pos_t      pos_reg,      pos_next;
    ffha_pkg::pos_t      nxt_reg,      nxt_next;
    ffha_pkg::pos_t      sz_reg,       sz_next;
    ffha_pkg::size_t     rem_reg,      rem_next;
    ffha_pkg::off_t      h_reg,        h_next;
    ffha_pkg::top_t      top_reg,      top_next;
    ffha_pkg::addr_t     res_addr_reg, res_addr_next;
    ffha_pkg::status_t   res_stat_reg, res_stat_next;
    logic                oval_reg,     oval_next;
    ffha_pkg::addr_t     oaddr_reg,    oaddr_next;
    ffha_pkg::status_t   ostat_reg,    ostat_next;

    ffha_pkg::alu_ctrl_t alu_ctrl;
    ffha_pkg::alu_res_t  alu_res;
    logic                fit;

    ffha_alu u_alu (
        .ctrl (alu_ctrl),
        .res  (alu_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        rq_next       = rq_reg;
        baddr_next    = baddr_reg;
        pos_next      = pos_reg;
        nxt_next      = nxt_reg;
        sz_next       = sz_reg;
        rem_next      = rem_reg;
        h_next        = h_reg;
        top_next      = top_reg;
        res_addr_next = res_addr_reg;
        res_stat_next = res_stat_reg;
        oval_next     = oval_reg;
        oaddr_next    = oaddr_reg;
        ostat_next    = ostat_reg;

        alu_ctrl      = '0;
        mem.we        = 1'b0;
        mem.waddr     = pos_reg[ffha_pkg::AW-1:0];
        mem.wdata     = '0;
        mem.raddr     = pos_reg[ffha_pkg::AW-1:0];

        fit = !rd_hdr.used && (ffha_pkg::pos_t'(rq_reg) <= ffha_pkg::pos_t'(rd_hdr.size));

        // drop the result beat once taken
        if (oval_reg && rsp.ready)
        begin
            oval_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    rq_next    = req.request_bytes;
                    baddr_next = req.block_address;
                    pos_next   = '0;
                    state_next = (req.func == ffha_pkg::FUNC_FREE) ? S_F_LO : S_A_TEST;
                end
            end

            S_A_TEST:
            begin
                alu_ctrl.a = ffha_pkg::alu_word_t'(pos_reg);
                alu_ctrl.c = ffha_pkg::alu_word_t'(top_reg);
                state_next = alu_res.lt ? S_A_EVAL : S_A_END;
            end

            S_A_EVAL:
            begin
                sz_next = ffha_pkg::pos_t'(rd_hdr.size);
                if (fit)
                begin
                    // split when at least one payload byte remains past a new header
                    alu_ctrl.a   = ffha_pkg::alu_word_t'(rq_reg);
                    alu_ctrl.hdr = 1'b1;
                    alu_ctrl.c   = ffha_pkg::alu_word_t'(rd_hdr.size);
                    mem.we       = 1'b1;
                    mem.wdata.used = 1'b1;
                    if (alu_res.lt)
                    begin
                        mem.wdata.size = ffha_pkg::size_t'(rq_reg);
                        state_next     = S_A_REM;
                    end
                    else
                    begin
                        mem.wdata.size = rd_hdr.size;
                        state_next     = S_A_ADDR;
                    end
                end
                else
                begin
                    alu_ctrl.a   = ffha_pkg::alu_word_t'(pos_reg);
                    alu_ctrl.b   = ffha_pkg::alu_word_t'(rd_hdr.size);
                    alu_ctrl.hdr = 1'b1;
                    pos_next     = ffha_pkg::pos_t'(alu_res.sum);
                    state_next   = S_A_TEST;
                end
            end

            S_A_REM:
            begin
                alu_ctrl.a   = ffha_pkg::alu_word_t'(sz_reg);
                alu_ctrl.b   = ffha_pkg::alu_word_t'(rq_reg);
                alu_ctrl.sub = 1'b1;
                alu_ctrl.hdr = 1'b1;
                rem_next     = ffha_pkg::size_t'(alu_res.sum);
                state_next   = S_A_SPLIT;
            end

            S_A_SPLIT:
            begin
                alu_ctrl.a     = ffha_pkg::alu_word_t'(pos_reg);
                alu_ctrl.b     = ffha_pkg::alu_word_t'(rq_reg);
                alu_ctrl.hdr   = 1'b1;
                mem.we         = 1'b1;
                mem.waddr      = ffha_pkg::off_t'(alu_res.sum);
                mem.wdata.used = 1'b0;
                mem.wdata.size = rem_reg;
                state_next     = S_A_ADDR;
            end

            S_A_ADDR:
            begin
                alu_ctrl.a    = ffha_pkg::alu_word_t'(heap_base);
                alu_ctrl.b    = ffha_pkg::alu_word_t'(pos_reg);
                alu_ctrl.hdr  = 1'b1;
                res_addr_next = alu_res.sum[ffha_pkg::ADDR_W-1:0];
                res_stat_next = ffha_pkg::ST_OK;
                state_next    = S_DONE;
            end

            S_A_END:
            begin
                alu_ctrl.a   = ffha_pkg::alu_word_t'(top_reg);
                alu_ctrl.b   = ffha_pkg::alu_word_t'(rq_reg);
                alu_ctrl.hdr = 1'b1;
                alu_ctrl.c   = ffha_pkg::alu_word_t'(ffha_pkg::HEAP_BYTES);
                if (alu_res.lt || alu_res.eq)
                begin
                    mem.we         = 1'b1;
                    mem.waddr      = ffha_pkg::off_t'(top_reg);
                    mem.wdata.used = 1'b1;
                    mem.wdata.size = ffha_pkg::size_t'(rq_reg);
                    pos_next       = ffha_pkg::pos_t'(top_reg);
                    top_next       = ffha_pkg::top_t'(alu_res.sum);
                    state_next     = S_A_ADDR;
                end
                else
                begin
                    res_addr_next = '0;
                    res_stat_next = ffha_pkg::ST_FULL;
                    state_next    = S_DONE;
                end
            end

            S_F_LO:
            begin
                alu_ctrl.a   = ffha_pkg::alu_word_t'(heap_base);
                alu_ctrl.hdr = 1'b1;
                alu_ctrl.c   = ffha_pkg::alu_word_t'(baddr_reg);
                if (alu_res.lt || alu_res.eq)
                begin
                    state_next = S_F_HI;
                end
                else
                begin
                    res_addr_next = '0;
                    res_stat_next = ffha_pkg::ST_RANGE;
                    state_next    = S_DONE;
                end
            end

            S_F_HI:
            begin
                alu_ctrl.a = ffha_pkg::alu_word_t'(heap_base);
                alu_ctrl.b = ffha_pkg::alu_word_t'(top_reg);
                alu_ctrl.c = ffha_pkg::alu_word_t'(baddr_reg);
                if (alu_res.lt)
                begin
                    res_addr_next = '0;
                    res_stat_next = ffha_pkg::ST_RANGE;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_F_RD;
                end
            end

            S_F_RD:
            begin
                alu_ctrl.a   = ffha_pkg::alu_word_t'(baddr_reg);
                alu_ctrl.b   = ffha_pkg::alu_word_t'(heap_base);
                alu_ctrl.sub = 1'b1;
                alu_ctrl.hdr = 1'b1;
                h_next       = ffha_pkg::off_t'(alu_res.sum);
                mem.raddr    = ffha_pkg::off_t'(alu_res.sum);
                state_next   = S_F_CLR;
            end

            S_F_CLR:
            begin
                mem.we         = 1'b1;
                mem.waddr      = h_reg;
                mem.wdata.used = 1'b0;
                mem.wdata.size = rd_hdr.size;
                pos_next       = '0;
                state_next     = S_M_TEST;
            end

            S_M_TEST:
            begin
                alu_ctrl.a = ffha_pkg::alu_word_t'(pos_reg);
                alu_ctrl.c = ffha_pkg::alu_word_t'(top_reg);
                if (alu_res.lt)
                begin
                    state_next = S_M_EVAL;
                end
                else
                begin
                    res_addr_next = '0;
                    res_stat_next = ffha_pkg::ST_OK;
                    state_next    = S_DONE;
                end
            end

            S_M_EVAL:
            begin
                alu_ctrl.a   = ffha_pkg::alu_word_t'(pos_reg);
                alu_ctrl.b   = ffha_pkg::alu_word_t'(rd_hdr.size);
                alu_ctrl.hdr = 1'b1;
                if (rd_hdr.used)
                begin
                    pos_next   = ffha_pkg::pos_t'(alu_res.sum);
                    state_next = S_M_TEST;
                end
                else
                begin
                    sz_next    = ffha_pkg::pos_t'(rd_hdr.size);
                    nxt_next   = ffha_pkg::pos_t'(alu_res.sum);
                    state_next = S_M_NTEST;
                end
            end

            S_M_NTEST:
            begin
                alu_ctrl.a = ffha_pkg::alu_word_t'(nxt_reg);
                alu_ctrl.c = ffha_pkg::alu_word_t'(top_reg);
                mem.raddr  = nxt_reg[ffha_pkg::AW-1:0];
                state_next = alu_res.lt ? S_M_NEVAL : S_M_WRITE;
            end

            S_M_NEVAL:
            begin
                alu_ctrl.a   = ffha_pkg::alu_word_t'(sz_reg);
                alu_ctrl.b   = ffha_pkg::alu_word_t'(rd_hdr.size);
                alu_ctrl.hdr = 1'b1;
                if (rd_hdr.used)
                begin
                    state_next = S_M_WRITE;
                end
                else
                begin
                    sz_next    = ffha_pkg::pos_t'(alu_res.sum);
                    state_next = S_M_NADV;
                end
            end

            S_M_NADV:
            begin
                // the follower always sits right after the end of the merged run
                alu_ctrl.a   = ffha_pkg::alu_word_t'(pos_reg);
                alu_ctrl.b   = ffha_pkg::alu_word_t'(sz_reg);
                alu_ctrl.hdr = 1'b1;
                nxt_next     = ffha_pkg::pos_t'(alu_res.sum);
                state_next   = S_M_NTEST;
            end

            S_M_WRITE:
            begin
                mem.we         = 1'b1;
                mem.waddr      = pos_reg[ffha_pkg::AW-1:0];
                mem.wdata.used = 1'b0;
                mem.wdata.size = ffha_pkg::size_t'(sz_reg);
                pos_next       = nxt_reg;
                state_next     = S_M_TEST;
            end

            S_DONE:
            begin
                if (!oval_reg || rsp.ready)
                begin
                    oval_next  = 1'b1;
                    oaddr_next = res_addr_reg;
                    ostat_next = res_stat_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rq_reg       <= '0;
            baddr_reg    <= '0;
            pos_reg      <= '0;
            nxt_reg      <= '0;
            sz_reg       <= '0;
            rem_reg      <= '0;
            h_reg        <= '0;
            top_reg      <= '0;
            res_addr_reg <= '0;
            res_stat_reg <= ffha_pkg::ST_OK;
            oval_reg     <= 1'b0;
            oaddr_reg    <= '0;
            ostat_reg    <= ffha_pkg::ST_OK;
        end
        else
        begin
            state_reg    <= state_next;
            rq_reg       <= rq_next;
            baddr_reg    <= baddr_next;
            pos_reg      <= pos_next;
            nxt_reg      <= nxt_next;
            sz_reg       <= sz_next;
            rem_reg      <= rem_next;
            h_reg        <= h_next;
            top_reg      <= top_next;
            res_addr_reg <= res_addr_next;
            res_stat_reg <= res_stat_next;
            oval_reg     <= oval_next;
            oaddr_reg    <= oaddr_next;
            ostat_reg    <= ostat_next;
        end
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = oval_reg;
    assign rsp.address   = oaddr_reg;
    assign rsp.status    = ostat_reg;

    assign stat.busy     = (state_reg != S_IDLE);
    assign stat.heap_top = top_reg;

endmodule

`default_nettype wire
